// File: rtl/core/pmp_pkg.sv
package pmp_pkg;

    localparam int CHAR_W       = 8;
    localparam int COEF_W       = 63;
    localparam int EXP_W        = 16;
    localparam int POLY_W       = 16;
    localparam int NUM_SLOTS    = 3;
    localparam int SLOT_W       = 2;
    localparam int NUM_VARS_DEF = 3;
    localparam int CFG_IDX_W    = 2;

    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam logic [CHAR_W-1:0] VAR_NAME_0_RST = 8'd120;
    localparam logic [CHAR_W-1:0] VAR_NAME_1_RST = 8'd121;
    localparam logic [CHAR_W-1:0] VAR_NAME_2_RST = 8'd122;
    localparam logic [SLOT_W-1:0] NUM_VARS_RST   = 2'd3;

    localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};
    localparam logic [EXP_W-1:0]  EXP_MAX  = {EXP_W{1'b1}};
    localparam logic [POLY_W-1:0] POLY_MAX = {POLY_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VAR_NAME_0 = 2'd0,
        CFG_VAR_NAME_1 = 2'd1,
        CFG_VAR_NAME_2 = 2'd2,
        CFG_NUM_VARS   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_LINE  = 3'd0,
        PH_MON   = 3'd1,
        PH_COEF  = 3'd2,
        PH_STAR  = 3'd3,
        PH_VAR   = 3'd4,
        PH_CARET = 3'd5,
        PH_EXP   = 3'd6
    } t_phase;

    typedef logic [NUM_SLOTS-1:0][CHAR_W-1:0] t_name_vec;
    typedef logic [NUM_SLOTS-1:0][EXP_W-1:0]  t_exp_vec;

    typedef struct packed {
        t_name_vec         var_names;
        logic [SLOT_W-1:0] num_vars;
    } t_cfg;

    typedef struct packed {
        logic [COEF_W-1:0] coefficient;
        t_exp_vec          exps;
        logic [POLY_W-1:0] poly_index;
        logic              parse_error;
    } t_result;

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic [3:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        d = c - CH_ZERO;
        return d[3:0];
    endfunction

endpackage

// File: rtl/core/pmp_cfg_regs.sv
module pmp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [pmp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pmp_pkg::CHAR_W-1:0]       i_cfg_data,
    output pmp_pkg::t_cfg                    o_cfg
);

    pmp_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.var_names[0] <= pmp_pkg::VAR_NAME_0_RST;
            r_cfg.var_names[1] <= pmp_pkg::VAR_NAME_1_RST;
            r_cfg.var_names[2] <= pmp_pkg::VAR_NAME_2_RST;
            r_cfg.num_vars     <= pmp_pkg::NUM_VARS_RST;
        end else if (i_cfg_valid) begin
            case (pmp_pkg::t_cfg_idx'(i_cfg_index))
                pmp_pkg::CFG_VAR_NAME_0: r_cfg.var_names[0] <= i_cfg_data;
                pmp_pkg::CFG_VAR_NAME_1: r_cfg.var_names[1] <= i_cfg_data;
                pmp_pkg::CFG_VAR_NAME_2: r_cfg.var_names[2] <= i_cfg_data;
                pmp_pkg::CFG_NUM_VARS:   r_cfg.num_vars <= i_cfg_data[pmp_pkg::SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/pmp_parse_core.sv
module pmp_parse_core #(
    parameter int NUM_VARS = pmp_pkg::NUM_VARS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [pmp_pkg::CHAR_W-1:0]   i_ch,
    input  logic                         i_is_end,
    input  pmp_pkg::t_cfg                i_cfg,
    output logic                         o_res_valid,
    output pmp_pkg::t_result             o_res
);

    localparam int EXP_W  = pmp_pkg::EXP_W;
    localparam int COEF_W = pmp_pkg::COEF_W;

    pmp_pkg::t_phase                r_phase, n_phase;
    logic [COEF_W-1:0]              r_coef, n_coef;
    logic [EXP_W-1:0]               r_exps [NUM_VARS];
    logic [EXP_W-1:0]               n_exps [NUM_VARS];
    logic [pmp_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [EXP_W-1:0]               r_exp_acc, n_exp_acc;
    logic [pmp_pkg::POLY_W-1:0]     r_poly, n_poly;
    logic                           r_err, n_err;

    logic                           c_term, c_plus, c_digit, c_letter, c_star, c_caret;
    logic                           c_open, c_bad, c_raise, c_emit;
    logic [3:0]                     c_dval;
    logic [COEF_W+3:0]              c_coef_sum;
    logic [COEF_W-1:0]              c_coef_next;
    logic [EXP_W+3:0]               c_exp_sum;
    logic [EXP_W-1:0]               c_exp_next;
    logic [pmp_pkg::SLOT_W-1:0]     c_match;
    logic                           c_found;
    pmp_pkg::t_exp_vec              c_exp_out;

    assign c_term   = i_is_end || (i_ch == pmp_pkg::CH_NL);
    assign c_plus   = !c_term && (i_ch == pmp_pkg::CH_PLUS);
    assign c_digit  = pmp_pkg::is_digit(i_ch);
    assign c_letter = pmp_pkg::is_letter(i_ch);
    assign c_star   = (i_ch == pmp_pkg::CH_STAR);
    assign c_caret  = (i_ch == pmp_pkg::CH_CARET);
    assign c_dval   = pmp_pkg::digit_val(i_ch);
    assign c_open   = (r_phase == pmp_pkg::PH_COEF) || (r_phase == pmp_pkg::PH_VAR) ||
                      (r_phase == pmp_pkg::PH_EXP);

    assign c_coef_sum  = ({4'b0, r_coef} << 3) + ({4'b0, r_coef} << 1) +
                         (COEF_W+4)'(c_dval);
    assign c_coef_next = (c_coef_sum[COEF_W+3:COEF_W] != 4'b0) ? pmp_pkg::COEF_MAX
                                                               : c_coef_sum[COEF_W-1:0];
    assign c_exp_sum   = ({4'b0, r_exp_acc} << 3) + ({4'b0, r_exp_acc} << 1) +
                         (EXP_W+4)'(c_dval);
    assign c_exp_next  = (c_exp_sum[EXP_W+3:EXP_W] != 4'b0) ? pmp_pkg::EXP_MAX
                                                            : c_exp_sum[EXP_W-1:0];

    always_comb begin
        c_match = r_slot;
        c_found = 1'b0;
        for (int k = 0; k < pmp_pkg::NUM_SLOTS; k++) begin
            if (!c_found && (pmp_pkg::SLOT_W'(k) < i_cfg.num_vars) && (k < NUM_VARS) &&
                (i_cfg.var_names[k] == i_ch)) begin
                c_match = pmp_pkg::SLOT_W'(k);
                c_found = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < pmp_pkg::NUM_SLOTS; g++) begin : g_exp_out
            if (g < NUM_VARS) begin : g_used
                assign c_exp_out[g] = r_exps[g];
            end else begin : g_unused
                assign c_exp_out[g] = '0;
            end
        end
    endgenerate

    always_comb begin
        case (r_phase)
            pmp_pkg::PH_LINE,
            pmp_pkg::PH_MON:   c_bad = !(c_digit || c_letter);
            pmp_pkg::PH_COEF:  c_bad = !(c_digit || c_star || c_letter);
            pmp_pkg::PH_STAR:  c_bad = !c_letter;
            pmp_pkg::PH_VAR:   c_bad = !(c_caret || c_star || c_letter);
            pmp_pkg::PH_CARET: c_bad = !c_digit;
            pmp_pkg::PH_EXP:   c_bad = !(c_digit || c_star || c_letter);
            default:           c_bad = 1'b0;
        endcase
    end

    always_comb begin
        c_raise = 1'b0;
        c_emit  = 1'b0;
        if (i_step && !r_err) begin
            if (c_term) begin
                c_raise = (r_phase == pmp_pkg::PH_STAR) || (r_phase == pmp_pkg::PH_CARET);
                c_emit  = !c_raise && c_open;
            end else if (c_plus) begin
                c_raise = !c_open;
                c_emit  = c_open;
            end else begin
                c_raise = c_bad;
            end
        end
        o_res_valid = c_raise || c_emit;
        if (c_raise) begin
            o_res             = '0;
            o_res.parse_error = 1'b1;
        end else begin
            o_res.coefficient = r_coef;
            o_res.exps        = c_exp_out;
            o_res.poly_index  = r_poly;
            o_res.parse_error = 1'b0;
        end
    end

    always_comb begin
        logic             exp_wr;
        logic [EXP_W-1:0] exp_val;
        logic             clear;
        n_phase   = r_phase;
        n_coef    = r_coef;
        n_exps    = r_exps;
        n_slot    = r_slot;
        n_exp_acc = r_exp_acc;
        n_poly    = r_poly;
        n_err     = r_err;
        exp_wr    = 1'b0;
        exp_val   = '0;
        clear     = 1'b0;
        if (i_step && !r_err) begin
            if (c_raise) begin
                n_err = 1'b1;
            end else if (c_term) begin
                if ((r_phase != pmp_pkg::PH_LINE) && (r_poly != pmp_pkg::POLY_MAX)) begin
                    n_poly = r_poly + 1'b1;
                end
                clear   = c_open;
                n_phase = pmp_pkg::PH_LINE;
            end else if (c_plus) begin
                clear   = 1'b1;
                n_phase = pmp_pkg::PH_MON;
            end else begin
                case (r_phase)
                    pmp_pkg::PH_LINE,
                    pmp_pkg::PH_MON: begin
                        if (c_digit) begin
                            n_coef  = COEF_W'(c_dval);
                            n_phase = pmp_pkg::PH_COEF;
                        end else begin
                            n_coef  = COEF_W'(1);
                            n_slot  = c_match;
                            exp_wr  = 1'b1;
                            exp_val = EXP_W'(1);
                            n_phase = pmp_pkg::PH_VAR;
                        end
                    end
                    pmp_pkg::PH_CARET: begin
                        n_exp_acc = EXP_W'(c_dval);
                        exp_wr    = 1'b1;
                        exp_val   = EXP_W'(c_dval);
                        n_phase   = pmp_pkg::PH_EXP;
                    end
                    pmp_pkg::PH_COEF,
                    pmp_pkg::PH_STAR,
                    pmp_pkg::PH_VAR,
                    pmp_pkg::PH_EXP: begin
                        if (c_letter) begin
                            n_slot  = c_match;
                            exp_wr  = 1'b1;
                            exp_val = EXP_W'(1);
                            n_phase = pmp_pkg::PH_VAR;
                        end else if (c_star) begin
                            n_phase = pmp_pkg::PH_STAR;
                        end else if (c_caret) begin
                            n_phase = pmp_pkg::PH_CARET;
                        end else if (r_phase == pmp_pkg::PH_COEF) begin
                            n_coef = c_coef_next;
                        end else begin
                            n_exp_acc = c_exp_next;
                            exp_wr    = 1'b1;
                            exp_val   = c_exp_next;
                        end
                    end
                    default: begin
                        n_phase = pmp_pkg::PH_LINE;
                    end
                endcase
            end
        end
        for (int k = 0; k < NUM_VARS; k++) begin
            if (exp_wr && (int'(n_slot) == k)) begin
                n_exps[k] = exp_val;
            end
        end
        if (clear) begin
            n_coef    = '0;
            n_slot    = '0;
            n_exp_acc = '0;
            for (int k = 0; k < NUM_VARS; k++) begin
                n_exps[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= pmp_pkg::PH_LINE;
            r_coef    <= '0;
            r_slot    <= '0;
            r_exp_acc <= '0;
            r_poly    <= '0;
            r_err     <= 1'b0;
            for (int k = 0; k < NUM_VARS; k++) begin
                r_exps[k] <= '0;
            end
        end else begin
            r_phase   <= n_phase;
            r_coef    <= n_coef;
            r_slot    <= n_slot;
            r_exp_acc <= n_exp_acc;
            r_poly    <= n_poly;
            r_err     <= n_err;
            r_exps    <= n_exps;
        end
    end

endmodule

// File: rtl/core/polynomial_monomial_parser_unit.sv
// Polynomial text parser: one ASCII character per request on the input channel
// (is_end closes the text like a newline). Monomials are split at '+', lines at
// newline; each finished monomial leaves as one request with its saturating
// coefficient, one exponent per named variable slot and its line index. A syntax
// error sends one request with parse_error set and all other fields zero, after
// which the block drops all input until reset. Rate is one character per cycle while
// the output is not stalled: each character is held in the input register, passes the
// combinational parser logic (the constant multiply-by-ten accumulate) and its result
// is registered in the output register; a stalled result holds the next character in
// the input register. Variable names and the number of slots in use are written
// through the configuration port; the user must write them only while idle, the
// block itself does not enforce this.
module polynomial_monomial_parser_unit #(
    parameter int NUM_VARS = pmp_pkg::NUM_VARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [pmp_pkg::CHAR_W-1:0]      i_ch,
    input  logic                            i_is_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pmp_pkg::COEF_W-1:0]      o_coefficient,
    output logic [pmp_pkg::EXP_W-1:0]       o_exp_0,
    output logic [pmp_pkg::EXP_W-1:0]       o_exp_1,
    output logic [pmp_pkg::EXP_W-1:0]       o_exp_2,
    output logic [pmp_pkg::POLY_W-1:0]      o_poly_index,
    output logic                            o_parse_error,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pmp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pmp_pkg::CHAR_W-1:0]      i_cfg_data
);

    logic                           r_in_valid;
    logic [pmp_pkg::CHAR_W-1:0]     r_in_ch;
    logic                           r_in_end;
    logic                           r_out_valid;
    pmp_pkg::t_result               r_out;

    logic                           out_free;
    logic                           step;
    logic                           in_accept;
    logic                           res_valid;
    pmp_pkg::t_result               res;
    pmp_pkg::t_cfg                  cfg;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    pmp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pmp_parse_core #(
        .NUM_VARS (NUM_VARS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_ch        (r_in_ch),
        .i_is_end    (r_in_end),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_ch  <= i_ch;
            r_in_end <= i_is_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_coefficient = r_out.coefficient;
    assign o_exp_0       = r_out.exps[0];
    assign o_exp_1       = r_out.exps[1];
    assign o_exp_2       = r_out.exps[2];
    assign o_poly_index  = r_out.poly_index;
    assign o_parse_error = r_out.parse_error;

endmodule
